// File: sv/quaternion_normalize_scale_top_assert.svh
// Assertion macros for the quaternion normalize/scale block.
// Self-contained; taken in by the top-level RTL file, the only one that carries checks.
`ifndef QUATERNION_NORMALIZE_SCALE_TOP_ASSERT_SVH
`define QUATERNION_NORMALIZE_SCALE_TOP_ASSERT_SVH

// Same-cycle implication check.
`define QNS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// Next-cycle implication check.
`define QNS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// File: sv/qns_pkg.sv
// Shared constants and types of the quaternion normalize/scale block.
// No dependencies.
package qns_pkg;

   localparam int FRAC_BITS_DEF = 12;
   localparam int MAG_W         = 16;
   localparam int SQ_W          = 2 * MAG_W;
   localparam int NORM_W        = SQ_W + 1;
   localparam int ROOT_SHIFT    = 16;
   localparam int NUM_EXTRA     = MAG_W + 2 * ROOT_SHIFT;
   localparam int ROUND_HALF    = 1 << (ROOT_SHIFT - 1);
   localparam int POS_MAX       = 32767;
   localparam int NEG_MAX       = 32768;

   typedef struct packed {
      logic [3:0][MAG_W-1:0] qm;
      logic [3:0]            qn;
      logic                  zero;
   } side_type;

   typedef struct packed {
      logic [3:0][MAG_W-1:0] q;
      logic                  zero;
      logic                  sat;
   } res_type;

endpackage

// File: sv/qns_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qns_pkg.
module qns_div #(
   parameter int FRAC_BITS = qns_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_valid,
   input  logic [FRAC_BITS+qns_pkg::NUM_EXTRA-1:0]   in_num,
   input  logic [qns_pkg::NORM_W-1:0]                in_norm,
   input  qns_pkg::side_type                         in_side,
   output logic                                      out_valid,
   output logic [FRAC_BITS+qns_pkg::NUM_EXTRA-1:0]   out_quo,
   output qns_pkg::side_type                         out_side
);
   import qns_pkg::*;

   localparam int NUM_W = FRAC_BITS + NUM_EXTRA;

   logic [NUM_W-1:0]  num_st  [NUM_W+1];
   logic [NORM_W-1:0] rem_st  [NUM_W+1];
   logic [NORM_W-1:0] norm_st [NUM_W+1];
   side_type          side_st [NUM_W+1];
   logic              vld_st  [NUM_W+1];

   assign num_st[0]  = in_num;
   assign rem_st[0]  = '0;
   assign norm_st[0] = in_norm;
   assign side_st[0] = in_side;
   assign vld_st[0]  = in_valid;

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [NORM_W:0]   trial;
      logic [NORM_W:0]   diff;
      logic [NORM_W-1:0] rem_in;
      logic [NUM_W-1:0]  num_in;
      logic [NORM_W-1:0] rem_ff;
      logic [NUM_W-1:0]  num_ff;
      logic [NORM_W-1:0] norm_ff;
      side_type          side_ff;
      logic              valid_ff;

      always_comb begin
         trial = {rem_st[s], num_st[s][NUM_W-1]};
         diff  = trial - {1'b0, norm_st[s]};
         if (trial >= {1'b0, norm_st[s]}) begin
            rem_in = diff[NORM_W-1:0];
            num_in = {num_st[s][NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[NORM_W-1:0];
            num_in = {num_st[s][NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= vld_st[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            num_ff  <= num_in;
            norm_ff <= norm_st[s];
            side_ff <= side_st[s];
         end
      end

      assign num_st[s+1]  = num_ff;
      assign rem_st[s+1]  = rem_ff;
      assign norm_st[s+1] = norm_ff;
      assign side_st[s+1] = side_ff;
      assign vld_st[s+1]  = valid_ff;
   end

   assign out_valid = vld_st[NUM_W];
   assign out_quo   = num_st[NUM_W];
   assign out_side  = side_st[NUM_W];

endmodule

// File: sv/qns_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on qns_pkg.
module qns_sqrt #(
   parameter int FRAC_BITS = qns_pkg::FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  logic [FRAC_BITS+qns_pkg::NUM_EXTRA-1:0]         in_rad,
   input  qns_pkg::side_type                               in_side,
   output logic                                            out_valid,
   output logic [(FRAC_BITS+qns_pkg::NUM_EXTRA+1)/2-1:0]   out_root,
   output qns_pkg::side_type                               out_side
);
   import qns_pkg::*;

   localparam int NUM_W  = FRAC_BITS + NUM_EXTRA;
   localparam int ROOT_W = (NUM_W + 1) / 2;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_st  [ROOT_W+1];
   logic [REM_W-1:0]  rem_st  [ROOT_W+1];
   logic [ROOT_W-1:0] root_st [ROOT_W+1];
   side_type          side_st [ROOT_W+1];
   logic              vld_st  [ROOT_W+1];

   assign rad_st[0]  = RAD_W'(in_rad);
   assign rem_st[0]  = '0;
   assign root_st[0] = '0;
   assign side_st[0] = in_side;
   assign vld_st[0]  = in_valid;

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [REM_W-1:0]  rem_t;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W-1:0]  rem_ff;
      logic [ROOT_W-1:0] root_ff;
      logic [RAD_W-1:0]  rad_ff;
      side_type          side_ff;
      logic              valid_ff;

      always_comb begin
         rem_t  = {rem_st[s][REM_W-3:0], rad_st[s][RAD_W-1:RAD_W-2]};
         trial  = {root_st[s], 2'b01};
         rad_in = {rad_st[s][RAD_W-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {root_st[s][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {root_st[s][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= vld_st[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= rad_in;
            side_ff <= side_st[s];
         end
      end

      assign rad_st[s+1]  = rad_ff;
      assign rem_st[s+1]  = rem_ff;
      assign root_st[s+1] = root_ff;
      assign side_st[s+1] = side_ff;
      assign vld_st[s+1]  = valid_ff;
   end

   assign out_valid = vld_st[ROOT_W];
   assign out_root  = root_st[ROOT_W];
   assign out_side  = side_st[ROOT_W];

endmodule

// File: sv/qns_scale.sv
// Scales component magnitudes by the root, rounds, restores sign, saturates.
// Depends on qns_pkg.
module qns_scale #(
   parameter int FRAC_BITS = qns_pkg::FRAC_BITS_DEF
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            en,
   input  logic                                            in_valid,
   input  logic [(FRAC_BITS+qns_pkg::NUM_EXTRA+1)/2-1:0]   in_root,
   input  qns_pkg::side_type                               in_side,
   output logic                                            out_valid,
   output qns_pkg::res_type                                out_res
);
   import qns_pkg::*;

   localparam int NUM_W  = FRAC_BITS + NUM_EXTRA;
   localparam int ROOT_W = (NUM_W + 1) / 2;
   localparam int PROD_W = MAG_W + ROOT_W;
   localparam int M_W    = PROD_W + 1 - ROOT_SHIFT;

   logic [PROD_W-1:0] prod_in  [4];
   logic [PROD_W-1:0] prod_ff  [4];
   side_type          side_ff;
   logic              mul_valid_ff;
   res_type           res_in;
   res_type           res_ff;
   logic              res_valid_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         prod_in[i] = PROD_W'(in_side.qm[i]) * PROD_W'(in_root);
      end
   end

   always_comb begin
      logic [PROD_W:0]  sum;
      logic [M_W-1:0]   m;
      logic [MAG_W-1:0] mag;
      logic             clip;
      res_in.sat  = 1'b0;
      res_in.zero = side_ff.zero;
      for (int i = 0; i < 4; i++) begin
         sum  = (PROD_W+1)'(prod_ff[i]) + (PROD_W+1)'(ROUND_HALF);
         m    = sum[PROD_W:ROOT_SHIFT];
         clip = side_ff.qn[i] ? (m > M_W'(NEG_MAX)) : (m > M_W'(POS_MAX));
         if (clip) begin
            mag = side_ff.qn[i] ? MAG_W'(NEG_MAX) : MAG_W'(POS_MAX);
         end else begin
            mag = m[MAG_W-1:0];
         end
         res_in.q[i] = side_ff.qn[i] ? (~mag + 1'b1) : mag;
         if (clip) begin
            res_in.sat = 1'b1;
         end
      end
      // Clear the components and the saturation flag for a zero-length quaternion.
      if (side_ff.zero) begin
         res_in.q   = '0;
         res_in.sat = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= in_valid;
         res_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         side_ff <= in_side;
         res_ff  <= res_in;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_res   = res_ff;

endmodule

// File: sv/quaternion_normalize_scale_top.sv
// Quaternion normalize and scale: q * sqrt(|scale| / |q|^2), Q4.12 in and out.
// Throughput: one transaction per cycle while the skid is empty; the depth
// comes from the bit-per-stage divider (FRAC_BITS + 48 stages) and the
// bit-per-stage square root that follows.
// Reset clears every valid bit, output and skid included; data regs keep.
// Depends on qns_pkg, qns_div, qns_sqrt, qns_scale and the assertion header.
`include "quaternion_normalize_scale_top_assert.svh"

module quaternion_normalize_scale_top #(
   parameter int FRAC_BITS = qns_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_scale_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w,
   output logic               rsp_zero_norm,
   output logic               rsp_saturated
);
   import qns_pkg::*;

   localparam int NUM_W  = FRAC_BITS + NUM_EXTRA;
   localparam int ROOT_W = (NUM_W + 1) / 2;

   // Whole pipeline advances together; it halts only while the skid holds
   // a transaction, so the stall toward the requester is a plain flop.
   logic en;

   logic [MAG_W-1:0]  raw   [4];
   side_type          a_side_in;
   logic [MAG_W-1:0]  a_smag_in;
   side_type          a_side_ff;
   logic [MAG_W-1:0]  a_smag_ff;
   logic              a_valid_ff;

   logic [SQ_W-1:0]   b_sq_in [4];
   logic [SQ_W-1:0]   b_sq_ff [4];
   side_type          b_side_ff;
   logic [MAG_W-1:0]  b_smag_ff;
   logic              b_valid_ff;

   logic [NORM_W-1:0] c_norm_in;
   logic [NUM_W-1:0]  c_num_in;
   side_type          c_side_in;
   logic [NORM_W-1:0] c_norm_ff;
   logic [NUM_W-1:0]  c_num_ff;
   side_type          c_side_ff;
   logic              c_valid_ff;

   logic              d_valid;
   logic [NUM_W-1:0]  d_quo;
   side_type          d_side;
   logic              s_valid;
   logic [ROOT_W-1:0] s_root;
   side_type          s_side;
   logic              p_valid;
   res_type           p_res;

   res_type           out_ff;
   logic              out_valid_ff;
   res_type           skid_ff;
   logic              skid_valid_ff;
   logic              out_q_zero;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage A: split each component into sign and magnitude.
   always_comb begin
      raw[0] = req_quat_x;
      raw[1] = req_quat_y;
      raw[2] = req_quat_z;
      raw[3] = req_quat_w;
      a_side_in.zero = 1'b0;
      for (int i = 0; i < 4; i++) begin
         a_side_in.qn[i] = raw[i][MAG_W-1];
         a_side_in.qm[i] = raw[i][MAG_W-1] ? (~raw[i] + 1'b1) : raw[i];
      end
      // |-32768| is 32768, which still fits 16 unsigned bits.
      a_smag_in = req_scale_in[MAG_W-1] ? (~req_scale_in + 1'b1) : req_scale_in;
   end

   // Stage B: square the magnitudes.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         b_sq_in[i] = SQ_W'(a_side_ff.qm[i]) * SQ_W'(a_side_ff.qm[i]);
      end
   end

   // Stage C: sum of squares, dividend and zero-length detect.
   always_comb begin
      c_norm_in = NORM_W'(b_sq_ff[0]) + NORM_W'(b_sq_ff[1])
                + NORM_W'(b_sq_ff[2]) + NORM_W'(b_sq_ff[3]);
      c_num_in  = NUM_W'(b_smag_ff) << (FRAC_BITS + 2 * ROOT_SHIFT);
      c_side_in      = b_side_ff;
      c_side_in.zero = (c_norm_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         a_smag_ff <= a_smag_in;
         b_sq_ff   <= b_sq_in;
         b_side_ff <= a_side_ff;
         b_smag_ff <= a_smag_ff;
         c_norm_ff <= c_norm_in;
         c_num_ff  <= c_num_in;
         c_side_ff <= c_side_in;
      end
   end

   // Ratio |scale| << (F + 32) / norm; a zero norm gives junk, masked later.
   qns_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .in_num    (c_num_ff),
      .in_norm   (c_norm_ff),
      .in_side   (c_side_ff),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   qns_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_rad    (d_quo),
      .in_side   (d_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   qns_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_side   (s_side),
      .out_valid (p_valid),
      .out_res   (p_res)
   );

   // Output register plus one skid entry. When the output is stalled the
   // pipeline tail lands in the skid, and the pipeline holds next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= p_valid;
         end
      end else if (en && p_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         out_ff <= skid_valid_ff ? skid_ff : p_res;
      end
      if (out_valid_ff && rsp_stall && en && p_valid) begin
         skid_ff <= p_res;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_x     = out_ff.q[0];
   assign rsp_out_y     = out_ff.q[1];
   assign rsp_out_z     = out_ff.q[2];
   assign rsp_out_w     = out_ff.q[3];
   assign rsp_zero_norm = out_ff.zero;
   assign rsp_saturated = out_ff.sat;

   assign out_q_zero = (out_ff.q == '0);

   `QNS_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `QNS_ASSERT_IMP(a_zero_norm_clean, clock, reset, rsp_valid && rsp_zero_norm, out_q_zero && !rsp_saturated)
   `QNS_ASSERT_NXT(a_tail_into_skid, clock, reset, out_valid_ff && rsp_stall && !skid_valid_ff && p_valid, skid_valid_ff)

endmodule

// File: verif/quaternion_normalize_scale_checker.sv
// Checker for the quaternion normalize/scale block: watches both channels,
// predicts each result in fixed point and compares it. Depends on qns_pkg.
`timescale 1ns / 100ps

module quaternion_normalize_scale_checker #(
   parameter int FRAC_BITS = qns_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_scale_in,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_out_x,
   input  logic signed [15:0] rsp_out_y,
   input  logic signed [15:0] rsp_out_z,
   input  logic signed [15:0] rsp_out_w,
   input  logic               rsp_zero_norm,
   input  logic               rsp_saturated,
   output int                 error_count,
   output int                 pending_count
);
   import qns_pkg::*;

   typedef struct {
      logic [15:0] comp [4];
      logic        zero;
      logic        sat;
   } scaled_quat_type;

   scaled_quat_type expected_q[$];

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bit_pos;
      root    = '0;
      bit_pos = 64'd1 << 62;
      while (bit_pos > v) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (v >= root + bit_pos) begin
            v    = v - (root + bit_pos);
            root = (root >> 1) + bit_pos;
         end else begin
            root = root >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return root;
   endfunction

   function automatic scaled_quat_type normalize_scale(logic [15:0] q [4], logic [15:0] s);
      scaled_quat_type r;
      logic [63:0]     mag [4];
      logic            neg [4];
      logic [63:0]     smag;
      logic [63:0]     norm;
      logic [63:0]     ratio;
      logic [63:0]     root;
      logic [63:0]     m;
      norm   = '0;
      r.sat  = 1'b0;
      r.zero = 1'b0;
      smag   = s[15] ? 64'h10000 - {48'd0, s} : {48'd0, s};
      for (int i = 0; i < 4; i++) begin
         neg[i] = q[i][15];
         mag[i] = neg[i] ? 64'h10000 - {48'd0, q[i]} : {48'd0, q[i]};
         norm   = norm + mag[i] * mag[i];
      end
      if (norm == 0) begin
         for (int i = 0; i < 4; i++) r.comp[i] = '0;
         r.zero = 1'b1;
         return r;
      end
      ratio = (smag << (FRAC_BITS + 2 * ROOT_SHIFT)) / norm;
      root  = int_sqrt(ratio);
      for (int i = 0; i < 4; i++) begin
         m = (mag[i] * root + 64'(ROUND_HALF)) >> ROOT_SHIFT;
         if (neg[i]) begin
            if (m > 64'(NEG_MAX)) begin
               m     = 64'(NEG_MAX);
               r.sat = 1'b1;
            end
            r.comp[i] = 16'(64'h10000 - m);
         end else begin
            if (m > 64'(POS_MAX)) begin
               m     = 64'(POS_MAX);
               r.sat = 1'b1;
            end
            r.comp[i] = m[15:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   assign pending_count = expected_q.size();

   initial error_count = 0;

   always @(posedge clock) begin
      logic [15:0]     q [4];
      logic [15:0]     got [4];
      scaled_quat_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            q[0] = req_quat_x;
            q[1] = req_quat_y;
            q[2] = req_quat_z;
            q[3] = req_quat_w;
            expected_q.insert(expected_q.size(), normalize_scale(q, req_scale_in));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transaction", '0, '0);
            end else begin
               want   = expected_q.pop_front();
               got[0] = rsp_out_x;
               got[1] = rsp_out_y;
               got[2] = rsp_out_z;
               got[3] = rsp_out_w;
               for (int i = 0; i < 4; i++)
                  if (got[i] !== want.comp[i])
                     report_mismatch($sformatf("component %0d", i), got[i], want.comp[i]);
               if (rsp_zero_norm !== want.zero)
                  report_mismatch("zero_norm", {15'd0, rsp_zero_norm}, {15'd0, want.zero});
               if (rsp_saturated !== want.sat)
                  report_mismatch("saturated", {15'd0, rsp_saturated}, {15'd0, want.sat});
            end
         end
      end
   end
endmodule

// File: verif/quaternion_normalize_scale_top_tb.sv
// Testbench top for the quaternion normalize/scale block: drives transactions,
// stalls the result side and gives the verdict. Depends on the block top, the checker and qns_pkg.
`timescale 1ns / 100ps

module quaternion_normalize_scale_top_tb;
   localparam int LATENCY   = 96;
   localparam int NUM_RAND  = 1000;
   localparam int MAX_CYCLE = 400000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_quat_x;
   logic signed [15:0] req_quat_y;
   logic signed [15:0] req_quat_z;
   logic signed [15:0] req_quat_w;
   logic signed [15:0] req_scale_in;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;
   logic signed [15:0] rsp_out_w;
   logic               rsp_zero_norm;
   logic               rsp_saturated;
   int                 error_count;
   int                 pending_count;
   int                 cycle_count;
   int                 send_idle_pct;
   int                 recv_idle_pct;

   // 8 ns clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   quaternion_normalize_scale_top dut (.*);

   quaternion_normalize_scale_checker checker_i (.*);

   // Randomly stall the result side at the current idle rate.
   initial rsp_stall = 1'b0;
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // Bound the run in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Draw a component, biased toward extremes, small values and zero.
   function automatic logic [15:0] pick_component();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7fff;
         3: return 16'(int'($urandom_range(8)) - 4);
         4: return 16'(int'($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one transaction, hold it until accepted, idle afterwards at random.
   task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                            logic [15:0] w, logic [15:0] s);
      req_valid    <= 1'b1;
      req_quat_x   <= x;
      req_quat_y   <= y;
      req_quat_z   <= z;
      req_quat_w   <= w;
      req_scale_in <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_quat(pick_component(), pick_component(), pick_component(),
                   pick_component(), pick_component());
   endtask

   // Lower valid and wait until every result is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      cycle_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_quat_x    = '0;
      req_quat_y    = '0;
      req_quat_z    = '0;
      req_quat_w    = '0;
      req_scale_in  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero norm, zero scale, unit quaternions, extremes, saturation.
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_quat(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000);
      send_quat(16'h0000, 16'hf000, 16'h0000, 16'h0000, 16'h1000);
      send_quat(16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'hf000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h4000);
      send_quat(16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h1000);
      send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h7fff);
      send_quat(16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_quat(16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h7fff);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0001);
      send_quat(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h7fff);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h5555, 16'haaaa, 16'h3333, 16'hcccc, 16'h5a5a);

      // Pause until the pipeline has emptied.
      drain();

      send_idle_pct = 36;
      recv_idle_pct = 62;
      send_random(NUM_RAND / 3);
      drain();
      send_idle_pct = 62;
      recv_idle_pct = 36;
      send_random(NUM_RAND / 3);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(NUM_RAND - 2 * (NUM_RAND / 3));
      drain();

      // Let any stray output surface before the verdict.
      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
